/* hdl/psf_pkg.sv */
`default_nettype none

package psf_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SEQ_W  = 16;

  // Highest sequence value: a stored entry at this value accepts any lower one (wrap).
  localparam logic [SEQ_W-1:0] SEQ_WRAP = {SEQ_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input item, restart the scan
    logic scan;    // issue the next table read, compare the last one
    logic latch;   // hold the lookup outcome
    logic commit;  // write the table, load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // compared entry matches the source
    logic miss;      // all filled entries compared, no match
    logic out_busy;  // result register still waits for its transfer
  } sts_t;

endpackage

`default_nettype wire

/* hdl/psf_ctrl.sv */
`default_nettype none

module psf_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire psf_pkg::sts_t sts,
  output psf_pkg::cmd_t     cmd
);
  import psf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.miss) begin
          cmd.latch = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a transfer in starts a scan on the next cycle
  a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SCAN))
    else $error("load did not start a scan");

  // commit only while the result register is free
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while result register busy");

  // a latched lookup outcome moves the controller to the finish state
  a_latch_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> (state_r == ST_FINISH))
    else $error("lookup outcome not followed by finish");

endmodule

`default_nettype wire

/* hdl/psf_datapath.sv */
`default_nettype none

module psf_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [psf_pkg::ADDR_W-1:0]  in_source_address,
  input  wire logic [psf_pkg::SEQ_W-1:0]   in_sequence_number,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_is_new,
  output logic                             out_stored,
  input  wire psf_pkg::cmd_t               cmd,
  output psf_pkg::sts_t                    sts
);
  import psf_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  entry_t            mem [TABLE_ENTRIES];

  logic [ADDR_W-1:0] key_addr_r;
  logic [SEQ_W-1:0]  key_seq_r;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     count_r;
  logic              rd_vld_r;
  entry_t            rd_data_r;
  logic [IW-1:0]     rd_idx_r;
  logic              hit_r;
  logic              fresh_r;
  logic [IW-1:0]     hit_idx_r;
  logic              out_valid_r;
  logic              out_is_new_r;
  logic              out_stored_r;

  logic              idx_lt_count;
  logic              match;
  logic              fresh;
  logic              room;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;

  assign idx_lt_count = (idx_r < count_r);
  assign match        = rd_vld_r && (rd_data_r.addr == key_addr_r);
  // newer, or stored value at the top of the range and any other value arrives
  assign fresh        = (key_seq_r > rd_data_r.seq) ||
                        ((rd_data_r.seq == SEQ_WRAP) && (key_seq_r != SEQ_WRAP));
  assign room         = (count_r != CW'(TABLE_ENTRIES));
  assign wr_en        = cmd.commit && (hit_r ? fresh_r : room);
  assign wr_idx       = hit_r ? hit_idx_r : count_r[IW-1:0];

  assign sts.hit      = match;
  assign sts.miss     = !match && !idx_lt_count;
  assign sts.out_busy = out_valid_r && out_stall;

  // table: one read a cycle while scanning filled entries, at most one write at commit
  always_ff @(posedge clk) begin
    if (cmd.scan && idx_lt_count) begin
      rd_data_r <= mem[idx_r[IW-1:0]];
    end
    if (wr_en) begin
      mem[wr_idx] <= '{addr: key_addr_r, seq: key_seq_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_addr_r <= in_source_address;
      key_seq_r  <= in_sequence_number;
    end
    if (cmd.scan) begin
      rd_idx_r <= idx_r[IW-1:0];
    end
    if (cmd.latch) begin
      hit_r     <= match;
      fresh_r   <= fresh;
      hit_idx_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      out_is_new_r <= hit_r ? fresh_r : 1'b1;
      out_stored_r <= hit_r ? fresh_r : room;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld_r <= idx_lt_count;
        if (idx_lt_count) begin
          idx_r <= idx_r + CW'(1);
        end
      end
      if (cmd.commit && !hit_r && room) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_is_new = out_is_new_r;
  assign out_stored = out_stored_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_stored_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_stored_r || out_is_new_r))
    else $error("recorded frame reported as duplicate");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not present a result");

  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !hit_r && room) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not advance fill count");

endmodule

`default_nettype wire

/* hdl/per_source_sequence_filter_unit.sv */
`default_nettype none

// Receive-side duplicate frame filter. One item in per received frame: the
// sender address and the header sequence number. One item out per frame:
// is_new (forward upward) and stored (table entry written or updated).
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// The sender table holds TABLE_ENTRIES entries in a single-port memory,
// filled in order; a fill count marks which entries hold data.
// The scan reads one memory entry per cycle from index 0 and compares it
// with the source; it ends at the first match, or with no match once all
// filled entries are compared. The outcome is latched, then committed to the
// table and result register; in_stall is high for the whole lookup.
// A finished result sits in the output register; the next input transfer
// is taken while it waits. If the receiver stalls, the lookup after that
// holds at commit until the result register is free, table untouched.
// Reset (rst_n low, synchronous) empties the table via the fill count at
// once, with no clearing pass, and drops any pending result.
module per_source_sequence_filter_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [psf_pkg::ADDR_W-1:0]  in_source_address,
  input  wire logic [psf_pkg::SEQ_W-1:0]   in_sequence_number,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_is_new,
  output logic                             out_stored
);
  import psf_pkg::*;

  cmd_t cmd;  // sequencing commands
  sts_t sts;  // lookup status and output register occupancy

  psf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_source_address  (in_source_address),
    .in_sequence_number (in_sequence_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_new         (out_is_new),
    .out_stored         (out_stored),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

`default_nettype wire

/* sim/tb_per_source_sequence_filter_unit.sv */
`default_nettype none

module tb_per_source_sequence_filter_unit;

  import psf_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned RESET_CYCLES  = 7;
  // Settle well past the longest lookup, a scan over the whole table.
  localparam int unsigned DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 8;
  // Slowest honest run is about 1850 frames of full-table lookups; take it many times over.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned FRAMES_PER_PHASE = 450;
  localparam int unsigned REPORT_CAP    = 200;

  typedef struct packed {
    logic is_new;
    logic stored;
  } verdict_t;

  // Mirror of the sender table plus the queue of verdicts still owed by the block.
  class dup_filter_scoreboard;
    logic [ADDR_W-1:0] known_addr [TABLE_ENTRIES];
    logic [SEQ_W-1:0]  last_seq   [TABLE_ENTRIES];
    int unsigned       fill;
    verdict_t          verdicts_due [$];
    int unsigned       errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Work out the verdict for an accepted frame and update the mirror table.
    function void note_frame(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
      verdict_t v;
      int       hit;
      hit = -1;
      // first filled entry whose address matches wins
      for (int i = 0; i < int'(fill); i++) begin
        if (hit < 0 && known_addr[i] == addr) hit = i;
      end
      if (hit >= 0) begin
        // greater sequence, or any lower one once the entry sits at the wrap value
        v.is_new = (seq > last_seq[hit]) ||
                   (last_seq[hit] == SEQ_WRAP && seq < SEQ_WRAP);
        v.stored = v.is_new;
        if (v.is_new) last_seq[hit] = seq;
      end else if (fill < TABLE_ENTRIES) begin
        known_addr[fill] = addr;
        last_seq[fill]   = seq;
        fill++;
        v = '{is_new: 1'b1, stored: 1'b1};
      end else begin
        // table full: forwarded, not recorded
        v = '{is_new: 1'b1, stored: 1'b0};
      end
      verdicts_due = {verdicts_due, v};
    endfunction

    task report(input string msg);
      // keep the log readable on a badly broken build
      if (errors < REPORT_CAP) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(input logic is_new, input logic stored);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("result with nothing owed: is_new=%0b stored=%0b", is_new, stored));
        return;
      end
      want = verdicts_due.pop_front();
      if (is_new !== want.is_new)
        report($sformatf("is_new=%0b, expected %0b", is_new, want.is_new));
      if (stored !== want.stored)
        report($sformatf("stored=%0b, expected %0b", stored, want.stored));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [ADDR_W-1:0] in_source_address  = '0;
  logic [SEQ_W-1:0]  in_sequence_number = '0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic              out_is_new;
  logic              out_stored;

  // idling odds, in percent, set per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;

  dup_filter_scoreboard sb;

  always #5 clk = ~clk;

  per_source_sequence_filter_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_source_address (in_source_address),
    .in_sequence_number(in_sequence_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_new        (out_is_new),
    .out_stored        (out_stored)
  );

  // Receiver: random back-pressure, driven on the falling edge.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
  end

  // Result transfers are checked at the rising edge against the oldest verdict owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_is_new, out_stored);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("per_source_sequence_filter_unit: mismatch");
      $finish;
    end
  end

  // One input transfer. Idle gaps are decided before valid rises, so valid never
  // looks at stall; the payload is held until the transfer completes.
  task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_source_address  <= addr;
    in_sequence_number <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(addr, seq);
  endtask

  function automatic logic [ADDR_W-1:0] random_addr();
    logic [ADDR_W-1:0] a;
    a[31:0]       = $urandom;
    a[ADDR_W-1:32] = 16'($urandom_range(16'hFFFF));
    return a;
  endfunction

  // Mostly known senders with sequences placed around the stored value, so
  // fresh, duplicate, stale and wrap outcomes all turn up; the rest are
  // strangers that hit the full table.
  task automatic send_random_frame();
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  base;
    int unsigned       pick;
    int unsigned       k;
    if ($urandom_range(99) < 12 || sb.fill == 0) begin
      addr = random_addr();
      seq  = SEQ_W'($urandom_range(16'hFFFF));
    end else begin
      k    = $urandom_range(sb.fill - 1);
      addr = sb.known_addr[k];
      base = sb.last_seq[k];
      pick = $urandom_range(99);
      if (pick < 35)      seq = base + SEQ_W'($urandom_range(1, 8));
      else if (pick < 50) seq = base;
      else if (pick < 65) seq = base - SEQ_W'($urandom_range(1, 8));
      else if (pick < 75) seq = SEQ_WRAP;
      else if (pick < 80) seq = '0;
      else                seq = SEQ_W'($urandom_range(16'hFFFF));
    end
    send_frame(addr, seq);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, wrap handling, stale and repeated sequences,
    // then fill the table and knock on it with a stranger.
    send_frame('0, '0);                 // new sender, lowest values
    send_frame('1, SEQ_WRAP);           // new sender, highest values
    send_frame('1, SEQ_WRAP);           // repeated wrap value: duplicate
    send_frame('1, '0);                 // wrap: lower sequence accepted
    send_frame('1, '0);                 // equal: duplicate
    send_frame('0, 16'd5);              // greater: fresh
    send_frame('0, 16'd3);              // lower without wrap: stale
    send_frame('0, SEQ_WRAP);           // up to the wrap value
    send_frame('0, SEQ_WRAP);           // duplicate at the wrap value
    send_frame('0, SEQ_WRAP - SEQ_W'(1)); // wrap: just below is accepted
    while (sb.fill < TABLE_ENTRIES)
      send_frame(random_addr(), SEQ_W'($urandom_range(16'hFFFF)));
    send_frame(random_addr(), 16'd1);   // table full: forwarded, not recorded

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          out_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          out_stall_pct = 51;
        end
        default: begin
          send_idle_pct = 18;
          out_stall_pct = 18;
        end
      endcase
      repeat (FRAMES_PER_PHASE) send_random_frame();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("per_source_sequence_filter_unit: match");
    end else begin
      $display("per_source_sequence_filter_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
